[rtl/core/mwd_pkg.sv]
// Shared types and constants for the magic word packet deframer.
// No dependencies; every other file imports this package.
package mwd_pkg;

  // Fixed header layout: 4 sync bytes, length, ident, sequence id
  localparam int          HEADER_BYTES    = 12;
  localparam logic [3:0]  SYNC_BYTES      = 4'd4;
  localparam logic [3:0]  POS_LEN_LO      = 4'd4;
  localparam logic [3:0]  POS_LEN_HI      = 4'd5;
  localparam logic [3:0]  POS_IDENT_LO    = 4'd6;
  localparam logic [3:0]  POS_IDENT_HI    = 4'd7;
  localparam logic [3:0]  POS_SEQ_B0      = 4'd8;
  localparam logic [3:0]  POS_SEQ_B1      = 4'd9;
  localparam logic [3:0]  POS_SEQ_B2      = 4'd10;
  localparam logic [3:0]  HDR_COUNT_END   = 4'(HEADER_BYTES);
  localparam logic [15:0] HDR_LEN         = 16'(HEADER_BYTES);
  localparam logic [15:0] COMPRESS_BIT    = 16'h8000;

  // Default depth of the queue between front and back
  localparam int          QUEUE_DEPTH_DEF = 2;

  // Parser phase, one-hot
  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_HEAD = 3'b010,
    PH_DATA = 3'b100
  } phase_t;

  // One queued result item, ident still raw
  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] ident;
    logic [31:0] seq;
    logic        last;
    logic        empty;
    logic        err;
  } entry_t;

  // Queue to back-end handshake
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_out_t;

endpackage

[rtl/core/mwd_intf.sv]
// Channel interfaces: received bytes, result items, start word writes.
// Depends on mwd_pkg.
interface mwd_rx_if import mwd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mwd_res_if import mwd_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic [14:0] packet_ident;
  logic        is_compressed;
  logic [31:0] sequence_id;
  logic        last_of_packet;
  logic        empty_packet;
  logic        length_error;
  modport source (output valid, output payload_byte, output packet_ident,
                  output is_compressed, output sequence_id, output last_of_packet,
                  output empty_packet, output length_error, input ready);
  modport sink   (input valid, input payload_byte, input packet_ident,
                  input is_compressed, input sequence_id, input last_of_packet,
                  input empty_packet, input length_error, output ready);
endinterface

interface mwd_cfg_if import mwd_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [31:0] start_word;
  modport source (output valid, output start_word, input ready);
  modport sink   (input valid, input start_word, output ready);
endinterface

[rtl/core/mwd_front.sv]
// Front end: sync word hunt, header capture and payload byte classification.
// Depends on mwd_pkg and the channel interfaces; pushes items into mwd_queue.
module mwd_front import mwd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  mwd_rx_if.sink  rx,
  mwd_cfg_if.sink cfg,
  input  logic   q_ready,
  output logic   push,
  output entry_t push_entry
);

  logic [31:0] start_word;
  phase_t      phase, phase_next;
  logic [31:0] sync_window, sync_window_next;
  logic [3:0]  header_count, header_count_next;
  logic [15:0] total_length, total_length_next;
  logic [15:0] ident_word, ident_word_next;
  logic [31:0] seq_word, seq_word_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic        accept;
  logic        has_result;
  logic [7:0]  b;

  assign cfg.ready = 1'b1;
  assign rx.ready  = q_ready;
  assign accept    = rx.valid && q_ready;
  assign b         = rx.rx_byte;

  // Start word register
  always_ff @(posedge clk) begin
    if (rst) begin
      start_word <= '0;
    end else if (cfg.valid) begin
      start_word <= cfg.start_word;
    end
  end

  // Parser next state
  always_comb begin
    phase_next        = phase;
    sync_window_next  = sync_window;
    header_count_next = header_count;
    total_length_next = total_length;
    ident_word_next   = ident_word;
    seq_word_next     = seq_word;
    bytes_left_next   = bytes_left;
    has_result        = 1'b0;
    push_entry        = '0;
    unique case (phase)
      PH_HEAD: begin
        unique case (header_count)
          POS_LEN_LO:   total_length_next = {8'd0, b};
          POS_LEN_HI:   total_length_next = {b, total_length[7:0]};
          POS_IDENT_LO: ident_word_next   = {8'd0, b};
          POS_IDENT_HI: ident_word_next   = {b, ident_word[7:0]};
          POS_SEQ_B0:   seq_word_next     = {24'd0, b};
          POS_SEQ_B1:   seq_word_next     = {16'd0, b, seq_word[7:0]};
          POS_SEQ_B2:   seq_word_next     = {8'd0, b, seq_word[15:0]};
          default:      seq_word_next     = {b, seq_word[23:0]};
        endcase
        header_count_next = header_count + 4'd1;
        if (header_count_next == HDR_COUNT_END) begin
          // header complete: length checked here
          phase_next        = PH_HUNT;
          sync_window_next  = '0;
          header_count_next = '0;
          push_entry.ident  = ident_word_next;
          push_entry.seq    = seq_word_next;
          if (total_length < HDR_LEN) begin
            has_result       = 1'b1;
            push_entry.err   = 1'b1;
          end else if (total_length == HDR_LEN) begin
            has_result       = 1'b1;
            push_entry.last  = 1'b1;
            push_entry.empty = 1'b1;
          end else begin
            bytes_left_next = total_length - HDR_LEN;
            phase_next      = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        bytes_left_next  = bytes_left - 16'd1;
        has_result       = 1'b1;
        push_entry.data  = b;
        push_entry.ident = ident_word;
        push_entry.seq   = seq_word;
        push_entry.last  = (bytes_left_next == 16'd0);
        if (push_entry.last) begin
          phase_next        = PH_HUNT;
          sync_window_next  = '0;
          header_count_next = '0;
        end
      end
      default: begin
        // hunting: slide window, newest byte on top
        sync_window_next = {b, sync_window[31:8]};
        if (header_count < SYNC_BYTES) begin
          header_count_next = header_count + 4'd1;
        end
        if (header_count_next == SYNC_BYTES && sync_window_next == start_word) begin
          phase_next = PH_HEAD;
        end
      end
    endcase
  end

  assign push = accept && has_result;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      sync_window  <= '0;
      header_count <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      sync_window  <= sync_window_next;
      header_count <= header_count_next;
    end
  end

  // Header fields
  always_ff @(posedge clk) begin
    if (accept) begin
      total_length <= total_length_next;
      ident_word   <= ident_word_next;
      seq_word     <= seq_word_next;
      bytes_left   <= bytes_left_next;
    end
  end

endmodule

[rtl/core/mwd_queue.sv]
// Short register queue between front and back end.
// Depends on mwd_pkg for the entry type.
module mwd_queue import mwd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   push_ready,
  input  logic   pop,
  output q_out_t q_out
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t        mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign push_ready  = (count != FULL_CNT);
  assign q_out.valid = (count != '0);
  assign q_out.entry = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[rtl/core/mwd_back.sv]
// Back end: splits the ident and holds each result item in the output register.
// Depends on mwd_pkg and the result channel interface.
module mwd_back import mwd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_out_t    q_out,
  output logic      pop,
  mwd_res_if.source res
);

  logic load;

  assign load = q_out.valid && (!res.valid || res.ready);
  assign pop  = load;

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (!res.valid || res.ready) begin
      res.valid <= q_out.valid;
    end
  end

  // Output payload; compressed flag taken off the ident
  always_ff @(posedge clk) begin
    if (load) begin
      res.payload_byte   <= q_out.entry.data;
      res.packet_ident   <= q_out.entry.ident[14:0];
      res.is_compressed  <= |(q_out.entry.ident & COMPRESS_BIT);
      res.sequence_id    <= q_out.entry.seq;
      res.last_of_packet <= q_out.entry.last;
      res.empty_packet   <= q_out.entry.empty;
      res.length_error   <= q_out.entry.err;
    end
  end

endmodule

[rtl/core/magic_word_packet_deframer.sv]
// Magic word packet deframer, top level.
// A result item on res is registered twice: in the queue storage, then in the output register.
// Throughput: one byte per cycle, set by the combinational parser in the front end.
// The front stalls only when the queue is full, i.e. when res is back-pressured.
// Reset (rst, synchronous): hunting, window cleared, queue empty, start_word 0.
module magic_word_packet_deframer import mwd_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  mwd_rx_if.sink    rx,
  mwd_cfg_if.sink   cfg,
  mwd_res_if.source res
);

  logic   push;
  logic   push_ready;
  logic   pop;
  entry_t push_entry;
  q_out_t q_out;

  mwd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .cfg        (cfg),
    .q_ready    (push_ready),
    .push       (push),
    .push_entry (push_entry)
  );

  mwd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop        (pop),
    .q_out      (q_out)
  );

  mwd_back u_back (
    .clk   (clk),
    .rst   (rst),
    .q_out (q_out),
    .pop   (pop),
    .res   (res)
  );

endmodule

[test/magic_word_packet_deframer_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for magic_word_packet_deframer: byte stream in, payload items out.
// Depends on mwd_pkg, the mwd_*_if channel interfaces and the deframer top level.
module magic_word_packet_deframer_tb;
  import mwd_pkg::*;

  // One payload item as seen on the result channel
  typedef struct packed {
    logic [7:0]  payload;
    logic [14:0] ident;
    logic        comp;
    logic [31:0] seq;
    logic        last;
    logic        empty;
    logic        err;
  } frame_res_t;

  // Directed stimulus row: byte to send, optional hand-written expectation
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    frame_res_t want;
  } dir_row_t;

  localparam frame_res_t NO_RES        = '0;
  localparam frame_res_t SHORT_LEN_RES = '{payload: 8'h00, ident: 15'h7fff, comp: 1'b1,
                                           seq: 32'hffff_ffff, last: 1'b0, empty: 1'b0,
                                           err: 1'b1};
  localparam frame_res_t HDR_ONLY_RES  = '{payload: 8'h00, ident: 15'h0000, comp: 1'b0,
                                           seq: 32'h0000_0000, last: 1'b1, empty: 1'b1,
                                           err: 1'b0};
  localparam int DIR_ROWS      = 24;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_BYTES   = 180;
  localparam int LIMIT_NS      = 5_000_000;

  // Reset start word is zero: four zero bytes sync. Short length with all-ones
  // ident and sequence, then a header-only packet with all-zero fields.
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h0b, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'hff, 1'b0, NO_RES}, '{8'hff, 1'b0, NO_RES},
    '{8'hff, 1'b0, NO_RES}, '{8'hff, 1'b0, NO_RES},
    '{8'hff, 1'b0, NO_RES}, '{8'hff, 1'b1, SHORT_LEN_RES},
    '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h0c, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b1, HDR_ONLY_RES}
  };

  logic clk;
  logic rst;

  mwd_rx_if  rx_ch ();
  mwd_cfg_if cfg_ch ();
  mwd_res_if res_ch ();

  magic_word_packet_deframer u_top (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .cfg (cfg_ch),
    .res (res_ch)
  );

  // Deframer copy: state and start word
  phase_t      fr_phase;
  logic [31:0] fr_window;
  logic [3:0]  fr_count;
  logic [15:0] fr_len;
  logic [15:0] fr_ident;
  logic [31:0] fr_seq;
  logic [15:0] fr_left;
  logic [31:0] fr_start;

  frame_res_t due_payloads [$];
  int src_idle;
  int rcv_idle;
  int n_items;
  int n_results;
  int n_packets;
  int n_pkt_bytes;
  int n_fail;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Timeout
  initial begin
    #(LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

  function automatic void resume_hunt();
    fr_phase  = PH_HUNT;
    fr_window = '0;
    fr_count  = '0;
  endfunction

  function automatic frame_res_t make_res(logic [7:0] pb, logic last, logic empty, logic err);
    frame_res_t r;
    r.payload = pb;
    r.ident   = fr_ident[14:0];
    r.comp    = (fr_ident & COMPRESS_BIT) != 16'h0000;
    r.seq     = fr_seq;
    r.last    = last;
    r.empty   = empty;
    r.err     = err;
    return r;
  endfunction

  // Advance the deframer copy by one byte; returns 1 when a payload item is due
  function automatic bit deframe_byte(input logic [7:0] b, output frame_res_t r);
    bit got;
    got = 1'b0;
    r   = NO_RES;
    case (fr_phase)
      PH_HEAD: begin
        case (fr_count)
          POS_LEN_LO:   fr_len = {8'h00, b};
          POS_LEN_HI:   fr_len[15:8] = b;
          POS_IDENT_LO: fr_ident = {8'h00, b};
          POS_IDENT_HI: fr_ident[15:8] = b;
          POS_SEQ_B0:   fr_seq = {24'h000000, b};
          POS_SEQ_B1:   fr_seq[15:8] = b;
          POS_SEQ_B2:   fr_seq[23:16] = b;
          default:      fr_seq[31:24] = b;
        endcase
        fr_count = fr_count + 4'd1;
        if (fr_count == HDR_COUNT_END) begin
          resume_hunt();
          if (fr_len < HDR_LEN) begin
            r   = make_res(8'h00, 1'b0, 1'b0, 1'b1);
            got = 1'b1;
          end else if (fr_len == HDR_LEN) begin
            r   = make_res(8'h00, 1'b1, 1'b1, 1'b0);
            got = 1'b1;
          end else begin
            fr_left  = fr_len - HDR_LEN;
            fr_phase = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        fr_left = fr_left - 16'd1;
        r   = make_res(b, fr_left == 16'd0, 1'b0, 1'b0);
        got = 1'b1;
        if (fr_left == 16'd0) resume_hunt();
      end
      default: begin
        // Hunting: newest byte enters at the top of the window
        fr_phase  = PH_HUNT;
        fr_window = {b, fr_window[31:8]};
        if (fr_count < SYNC_BYTES) fr_count = fr_count + 4'd1;
        if (fr_count >= SYNC_BYTES && fr_window == fr_start) begin
          fr_phase = PH_HEAD;
          fr_count = SYNC_BYTES;
        end
      end
    endcase
    return got;
  endfunction

  // Noise never equals a sync byte, so no stray match can start a packet
  function automatic logic [7:0] noise_byte();
    logic [7:0] nb;
    do begin
      nb = 8'($urandom);
    end while (nb == fr_start[7:0] || nb == fr_start[15:8] ||
               nb == fr_start[23:16] || nb == fr_start[31:24]);
    return nb;
  endfunction

  // Send one item; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic typed, input frame_res_t want);
    frame_res_t r;
    while ($urandom_range(99) < src_idle) begin
      rx_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    n_items++;
    if (deframe_byte(b, r)) due_payloads.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  task automatic send_packet(input logic [15:0] len, input logic [15:0] ident,
                             input logic [31:0] seq);
    for (int i = 0; i < 4; i++) send_byte(fr_start[8*i +: 8], 1'b0, NO_RES);
    send_byte(len[7:0], 1'b0, NO_RES);
    send_byte(len[15:8], 1'b0, NO_RES);
    send_byte(ident[7:0], 1'b0, NO_RES);
    send_byte(ident[15:8], 1'b0, NO_RES);
    for (int i = 0; i < 4; i++) send_byte(seq[8*i +: 8], 1'b0, NO_RES);
    for (int k = 0; k < int'(len) - HEADER_BYTES; k++) send_byte(8'($urandom), 1'b0, NO_RES);
    n_packets++;
    n_pkt_bytes += (int'(len) > HEADER_BYTES) ? int'(len) : HEADER_BYTES;
  endtask

  // Optional leading noise or broken sync, then a packet of short, header-only or longer length
  task automatic random_packet();
    int pick;
    int k;
    logic [15:0] len;
    pick = $urandom_range(99);
    if (pick < 25) begin
      repeat ($urandom_range(1, 3)) send_byte(noise_byte(), 1'b0, NO_RES);
    end else if (pick < 40) begin
      k = $urandom_range(1, 3);
      for (int i = 0; i < k; i++) send_byte(fr_start[8*i +: 8], 1'b0, NO_RES);
      send_byte(noise_byte(), 1'b0, NO_RES);
    end
    pick = $urandom_range(99);
    if (pick < 8)       len = 16'($urandom_range(0, HEADER_BYTES - 1));
    else if (pick < 18) len = HDR_LEN;
    else if (pick < 92) len = 16'($urandom_range(HEADER_BYTES + 1, 44));
    else                len = 16'($urandom_range(45, 300));
    send_packet(len, 16'($urandom), $urandom);
  endtask

  // Hold the sender until every due item is out and the pipe has settled
  task automatic drain_results();
    rx_ch.valid <= 1'b0;
    while (due_payloads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_start(input logic [31:0] w);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.start_word <= w;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    fr_start = w;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_fail++;
    end
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= rcv_idle);
  end

  // Result checker
  always @(posedge clk) begin : res_check
    frame_res_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      n_results++;
      if (due_payloads.size() == 0) begin
        $error("result item with nothing expected");
        n_fail++;
      end else begin
        want = due_payloads.pop_front();
        cmp_field("payload_byte", 32'(want.payload), 32'(res_ch.payload_byte));
        cmp_field("packet_ident", 32'(want.ident), 32'(res_ch.packet_ident));
        cmp_field("is_compressed", 32'(want.comp), 32'(res_ch.is_compressed));
        cmp_field("sequence_id", want.seq, res_ch.sequence_id);
        cmp_field("last_of_packet", 32'(want.last), 32'(res_ch.last_of_packet));
        cmp_field("empty_packet", 32'(want.empty), 32'(res_ch.empty_packet));
        cmp_field("length_error", 32'(want.err), 32'(res_ch.length_error));
      end
    end
  end

  // Stimulus sequence
  initial begin
    int target;
    rst               = 1'b1;
    rx_ch.valid       = 1'b0;
    rx_ch.rx_byte     = 8'h00;
    cfg_ch.valid      = 1'b0;
    cfg_ch.start_word = 32'h0000_0000;
    res_ch.ready      = 1'b0;
    src_idle          = 27;
    rcv_idle          = 81;
    n_items           = 0;
    n_results         = 0;
    n_packets         = 0;
    n_pkt_bytes       = 0;
    n_fail            = 0;
    target            = 0;
    fr_start          = '0;
    fr_len            = '0;
    fr_ident          = '0;
    fr_seq            = '0;
    fr_left           = '0;
    resume_hunt();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows under the reset start word
    for (int i = 0; i < DIR_ROWS; i++) send_byte(dir_tab[i].rx, dir_tab[i].typed, dir_tab[i].want);
    drain_results();

    // Random start word, slow receiver
    write_start($urandom);
    target += PHASE_BYTES;
    while (n_pkt_bytes < target) random_packet();
    drain_results();

    // All-ones start word, slow sender; pause halfway until all items are out
    src_idle = 81;
    rcv_idle = 27;
    write_start(32'hffff_ffff);
    target += PHASE_BYTES / 2;
    while (n_pkt_bytes < target) random_packet();
    drain_results();
    target += PHASE_BYTES / 2;
    while (n_pkt_bytes < target) random_packet();
    drain_results();

    // No idling on either side
    src_idle = 0;
    rcv_idle = 0;
    write_start($urandom);
    target += PHASE_BYTES;
    while (n_pkt_bytes < target) random_packet();
    drain_results();

    $display("Sent %0d bytes in %0d packets over four start words and three idle mixes,",
             n_items, n_packets);
    $display("checked %0d result items including short, header-only and long packets.",
             n_results);
    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
